// ===== design/prt2d_pkg.sv =====
package prt2d_pkg;

   // Point and configuration formats.
   localparam int COORD_WIDTH     = 16;
   localparam int TRIG_FRAC_BITS  = 16;
   localparam int TRIG_WIDTH      = TRIG_FRAC_BITS + 2;
   localparam int OFFSET_WIDTH    = 16;
   localparam int ANGLE_WIDTH     = 17;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 17;

   // Register map of the configuration port.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MODE     = 2'd0,
      CSR_OFFSET_X = 2'd1,
      CSR_OFFSET_Y = 2'd2,
      CSR_ANGLE    = 2'd3
   } csr_index_type;

   // Transform kinds held in the mode register.
   localparam logic MODE_TRANSLATE = 1'b0;
   localparam logic MODE_ROTATE    = 1'b1;

   // Sine and cosine generator constants.
   localparam int CORDIC_STEPS      = 20;
   localparam int STEP_WIDTH        = $clog2(CORDIC_STEPS);
   localparam int WORK_FRAC         = 30;
   localparam int WORK_WIDTH        = WORK_FRAC + 3;
   localparam int ZACC_WIDTH        = 32;
   localparam int ZSCALE_SHIFT      = 16;
   localparam int TURN_WIDTH        = ANGLE_WIDTH + 1;
   localparam int REM_WIDTH         = 14;
   localparam int CORDIC_GAIN_INV   = 652032874;
   localparam int FULL_TURN_CDEG    = 36000;
   localparam int QUARTER_TURN_CDEG = 9000;

   // Cosine and sine as seen by the datapath.
   typedef struct packed {
      logic                         ready;
      logic signed [TRIG_WIDTH-1:0] cosine;
      logic signed [TRIG_WIDTH-1:0] sine;
   } trig_status_type;

   // Arctangent of 2^-step in units of 1/6553600 degree.
   function automatic logic signed [ZACC_WIDTH-1:0] atan_entry(
      input logic [STEP_WIDTH-1:0] step
   );
      logic signed [ZACC_WIDTH-1:0] value;
      case (step)
         5'd0:    value = 32'sd294912000;
         5'd1:    value = 32'sd174096719;
         5'd2:    value = 32'sd91987925;
         5'd3:    value = 32'sd46694507;
         5'd4:    value = 32'sd23437865;
         5'd5:    value = 32'sd11730358;
         5'd6:    value = 32'sd5866610;
         5'd7:    value = 32'sd2933484;
         5'd8:    value = 32'sd1466765;
         5'd9:    value = 32'sd733385;
         5'd10:   value = 32'sd366693;
         5'd11:   value = 32'sd183346;
         5'd12:   value = 32'sd91673;
         5'd13:   value = 32'sd45837;
         5'd14:   value = 32'sd22918;
         5'd15:   value = 32'sd11459;
         5'd16:   value = 32'sd5730;
         5'd17:   value = 32'sd2865;
         5'd18:   value = 32'sd1432;
         5'd19:   value = 32'sd716;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

// ===== design/prt2d_req_if.sv =====
interface prt2d_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [prt2d_pkg::COORD_WIDTH-1:0] point_x;
   logic signed [prt2d_pkg::COORD_WIDTH-1:0] point_y;

   modport source (output valid, output point_x, output point_y, input ready);
   modport sink (input valid, input point_x, input point_y, output ready);
endinterface

// ===== design/prt2d_rsp_if.sv =====
interface prt2d_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [prt2d_pkg::COORD_WIDTH-1:0] result_x;
   logic signed [prt2d_pkg::COORD_WIDTH-1:0] result_y;
   logic                                    clipped;

   modport source (output valid, output result_x, output result_y, output clipped,
                   input ready);
   modport sink (input valid, input result_x, input result_y, input clipped,
                 output ready);
endinterface

// ===== design/prt2d_trig.sv =====
module prt2d_trig (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     angle_load,
   input  logic signed [prt2d_pkg::ANGLE_WIDTH-1:0] angle_value,
   output prt2d_pkg::trig_status_type               status
);

   localparam int ROUND_SHIFT = prt2d_pkg::WORK_FRAC - prt2d_pkg::TRIG_FRAC_BITS;

   localparam logic signed [prt2d_pkg::TURN_WIDTH-1:0] FULL_TURN =
      prt2d_pkg::TURN_WIDTH'(prt2d_pkg::FULL_TURN_CDEG);
   localparam logic signed [prt2d_pkg::TURN_WIDTH-1:0] QUARTER_1 =
      prt2d_pkg::TURN_WIDTH'(prt2d_pkg::QUARTER_TURN_CDEG);
   localparam logic signed [prt2d_pkg::TURN_WIDTH-1:0] QUARTER_2 =
      prt2d_pkg::TURN_WIDTH'(2 * prt2d_pkg::QUARTER_TURN_CDEG);
   localparam logic signed [prt2d_pkg::TURN_WIDTH-1:0] QUARTER_3 =
      prt2d_pkg::TURN_WIDTH'(3 * prt2d_pkg::QUARTER_TURN_CDEG);
   localparam logic signed [prt2d_pkg::WORK_WIDTH-1:0] GAIN_INV =
      prt2d_pkg::WORK_WIDTH'(prt2d_pkg::CORDIC_GAIN_INV);
   localparam logic signed [prt2d_pkg::WORK_WIDTH-1:0] WORK_ONE =
      prt2d_pkg::WORK_WIDTH'(64'(1) << prt2d_pkg::WORK_FRAC);
   localparam logic signed [prt2d_pkg::WORK_WIDTH-1:0] ROUND_HALF =
      prt2d_pkg::WORK_WIDTH'(64'(1) << (ROUND_SHIFT - 1));
   localparam logic signed [prt2d_pkg::TRIG_WIDTH-1:0] TRIG_ONE =
      prt2d_pkg::TRIG_WIDTH'(64'(1) << prt2d_pkg::TRIG_FRAC_BITS);
   localparam logic [prt2d_pkg::STEP_WIDTH-1:0] LAST_STEP =
      prt2d_pkg::STEP_WIDTH'(prt2d_pkg::CORDIC_STEPS - 1);

   typedef enum logic [4:0] {
      TRIG_IDLE   = 5'b00001,
      TRIG_REDUCE = 5'b00010,
      TRIG_SPLIT  = 5'b00100,
      TRIG_ROTATE = 5'b01000,
      TRIG_FINISH = 5'b10000
   } trig_state_type;

   trig_state_type                            state_ff, state_in;
   logic signed [prt2d_pkg::TURN_WIDTH-1:0]   turn_ff, turn_in;
   logic [1:0]                                quad_ff, quad_in;
   logic signed [prt2d_pkg::WORK_WIDTH-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [prt2d_pkg::ZACC_WIDTH-1:0]   z_ff, z_in;
   logic [prt2d_pkg::STEP_WIDTH-1:0]          step_ff, step_in;
   logic signed [prt2d_pkg::TRIG_WIDTH-1:0]   cos_ff, cos_in, sin_ff, sin_in;

   logic [1:0]                                split_quad;
   logic signed [prt2d_pkg::TURN_WIDTH-1:0]   split_base;
   logic signed [prt2d_pkg::TURN_WIDTH-1:0]   split_rem_full;
   logic [prt2d_pkg::REM_WIDTH-1:0]           split_rem;
   logic signed [prt2d_pkg::WORK_WIDTH-1:0]   shift_x, shift_y;
   logic signed [prt2d_pkg::ZACC_WIDTH-1:0]   atan_val;
   logic signed [prt2d_pkg::WORK_WIDTH-1:0]   round_x, round_y;
   logic signed [prt2d_pkg::TRIG_WIDTH-1:0]   base_cos, base_sin;

   // Quadrant split of the reduced angle.
   always_comb begin
      if (turn_ff >= QUARTER_3) begin
         split_quad = 2'd3;
         split_base = QUARTER_3;
      end else if (turn_ff >= QUARTER_2) begin
         split_quad = 2'd2;
         split_base = QUARTER_2;
      end else if (turn_ff >= QUARTER_1) begin
         split_quad = 2'd1;
         split_base = QUARTER_1;
      end else begin
         split_quad = 2'd0;
         split_base = '0;
      end
      split_rem_full = turn_ff - split_base;
      split_rem      = split_rem_full[prt2d_pkg::REM_WIDTH-1:0];
   end

   // One micro-rotation per cycle.
   assign shift_x  = y_ff >>> step_ff;
   assign shift_y  = x_ff >>> step_ff;
   assign atan_val = prt2d_pkg::atan_entry(step_ff);

   // Round the working values half up to the trig format.
   assign round_x  = (x_ff + ROUND_HALF) >>> ROUND_SHIFT;
   assign round_y  = (y_ff + ROUND_HALF) >>> ROUND_SHIFT;
   assign base_cos = round_x[prt2d_pkg::TRIG_WIDTH-1:0];
   assign base_sin = round_y[prt2d_pkg::TRIG_WIDTH-1:0];

   // Sequencer for angle reduction, rotation and quadrant mapping.
   always_comb begin
      state_in = state_ff;
      turn_in  = turn_ff;
      quad_in  = quad_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      step_in  = step_ff;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      unique case (state_ff)
         TRIG_IDLE: begin
         end
         TRIG_REDUCE: begin
            if (turn_ff < 0) begin
               turn_in = turn_ff + FULL_TURN;
            end else if (turn_ff >= FULL_TURN) begin
               turn_in = turn_ff - FULL_TURN;
            end else begin
               state_in = TRIG_SPLIT;
            end
         end
         TRIG_SPLIT: begin
            quad_in = split_quad;
            y_in    = '0;
            step_in = '0;
            z_in    = prt2d_pkg::ZACC_WIDTH'({split_rem, {prt2d_pkg::ZSCALE_SHIFT{1'b0}}});
            if (split_rem == '0) begin
               // Exact multiple of a right angle: cosine one, sine zero.
               x_in     = WORK_ONE;
               state_in = TRIG_FINISH;
            end else begin
               x_in     = GAIN_INV;
               state_in = TRIG_ROTATE;
            end
         end
         TRIG_ROTATE: begin
            if (!z_ff[prt2d_pkg::ZACC_WIDTH-1]) begin
               x_in = x_ff - shift_x;
               y_in = y_ff + shift_y;
               z_in = z_ff - atan_val;
            end else begin
               x_in = x_ff + shift_x;
               y_in = y_ff - shift_y;
               z_in = z_ff + atan_val;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = TRIG_FINISH;
            end
         end
         TRIG_FINISH: begin
            case (quad_ff)
               2'd1: begin
                  cos_in = -base_sin;
                  sin_in = base_cos;
               end
               2'd2: begin
                  cos_in = -base_cos;
                  sin_in = -base_sin;
               end
               2'd3: begin
                  cos_in = base_sin;
                  sin_in = -base_cos;
               end
               default: begin
                  cos_in = base_cos;
                  sin_in = base_sin;
               end
            endcase
            state_in = TRIG_IDLE;
         end
         default: begin
            state_in = TRIG_IDLE;
         end
      endcase
      // A new angle restarts the sequence from any state.
      if (angle_load) begin
         turn_in  = prt2d_pkg::TURN_WIDTH'(angle_value);
         state_in = TRIG_REDUCE;
      end
   end

   // Control and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= TRIG_IDLE;
         cos_ff   <= TRIG_ONE;
         sin_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cos_ff   <= cos_in;
         sin_ff   <= sin_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      turn_ff <= turn_in;
      quad_ff <= quad_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
   end

   assign status.ready  = (state_ff == TRIG_IDLE);
   assign status.cosine = cos_ff;
   assign status.sine   = sin_ff;

endmodule

// ===== design/point_rotate_translate_2d_top.sv =====
// Planar point transform: translate by an offset or rotate by an angle.
// Points arrive on req_port (valid/ready, signed Q8.8 point_x and point_y);
// one result per point leaves on rsp_port (result_x, result_y, clipped), in
// order. A transfer happens on a rising clock edge with valid and ready high.
// The input register takes each point; its result is computed combinationally
// and held in the output register, from which it is offered on rsp_port.
// Throughput: one point per cycle while rsp_port.ready stays high and no angle
// is being generated, limited by the single pass through the two multipliers
// per coordinate between the input and result registers.
// The csr_ port writes mode, offset_x, offset_y and angle_centideg. Writing
// the angle starts the sine/cosine generator (range reduction, then a
// 20-step CORDIC, skipped for exact right angles); req_port.ready stays low
// until the new cosine and sine are in place. Configure only while no point is
// in flight.
// Reset (synchronous, active high) selects translate mode with zero offsets
// and a zero angle, and empties the pipeline.
// When the receiver holds rsp_port.ready low, the result waits in the
// output register while the input register still takes one more point;
// after that req_port.ready falls until the result is taken.
module point_rotate_translate_2d_top (
   input  logic                                   clock,
   input  logic                                   reset,
   prt2d_req_if.sink                              req_port,
   prt2d_rsp_if.source                            rsp_port,
   input  logic                                   csr_we,
   input  logic [prt2d_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [prt2d_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   localparam int CW         = prt2d_pkg::COORD_WIDTH;
   localparam int PROD_WIDTH = CW + prt2d_pkg::TRIG_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 1;
   localparam int RAW_WIDTH  = SUM_WIDTH - prt2d_pkg::TRIG_FRAC_BITS;

   localparam logic signed [SUM_WIDTH-1:0] SUM_HALF =
      SUM_WIDTH'(64'(1) << (prt2d_pkg::TRIG_FRAC_BITS - 1));
   localparam logic signed [RAW_WIDTH-1:0] RAW_MAX =
      RAW_WIDTH'((64'(1) << (CW - 1)) - 1);
   localparam logic signed [RAW_WIDTH-1:0] RAW_MIN = ~RAW_MAX;

   typedef struct packed {
      logic signed [CW-1:0] value;
      logic                 clip;
   } sat_type;

   // Clamp a wide result to the coordinate range.
   function automatic sat_type saturate(input logic signed [RAW_WIDTH-1:0] raw);
      sat_type res;
      res.clip = 1'b1;
      if (raw > RAW_MAX) begin
         res.value = {1'b0, {(CW - 1){1'b1}}};
      end else if (raw < RAW_MIN) begin
         res.value = {1'b1, {(CW - 1){1'b0}}};
      end else begin
         res.value = raw[CW-1:0];
         res.clip  = 1'b0;
      end
      return res;
   endfunction

   logic                                          mode_ff;
   logic signed [prt2d_pkg::OFFSET_WIDTH-1:0]     off_x_ff, off_y_ff;
   logic                                          angle_load;
   prt2d_pkg::trig_status_type                    trig;

   logic                                          s1_valid_ff, s1_valid_in;
   logic signed [CW-1:0]                          pt_x_ff, pt_y_ff;
   logic                                          rsp_valid_ff, rsp_valid_in;
   logic signed [CW-1:0]                          rsp_x_ff, rsp_y_ff;
   logic                                          rsp_clip_ff;

   logic                                          out_free, req_take, s1_move;
   logic signed [PROD_WIDTH-1:0]                  prod_xc, prod_ys, prod_yc, prod_xs;
   logic signed [SUM_WIDTH-1:0]                   sum_x, sum_y;
   logic signed [SUM_WIDTH-1:0]                   shr_x, shr_y;
   logic signed [RAW_WIDTH-1:0]                   raw_x, raw_y;
   sat_type                                       sat_x, sat_y;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= prt2d_pkg::MODE_TRANSLATE;
         off_x_ff <= '0;
         off_y_ff <= '0;
      end else if (csr_we) begin
         unique case (prt2d_pkg::csr_index_type'(csr_index))
            prt2d_pkg::CSR_MODE:     mode_ff  <= csr_wdata[0];
            prt2d_pkg::CSR_OFFSET_X: off_x_ff <= csr_wdata[prt2d_pkg::OFFSET_WIDTH-1:0];
            prt2d_pkg::CSR_OFFSET_Y: off_y_ff <= csr_wdata[prt2d_pkg::OFFSET_WIDTH-1:0];
            prt2d_pkg::CSR_ANGLE: begin
            end
            default: begin
            end
         endcase
      end
   end

   assign angle_load = csr_we &&
                       (prt2d_pkg::csr_index_type'(csr_index) == prt2d_pkg::CSR_ANGLE);

   // Cosine and sine generator.
   prt2d_trig u_trig (
      .clock       (clock),
      .reset       (reset),
      .angle_load  (angle_load),
      .angle_value ($signed(csr_wdata[prt2d_pkg::ANGLE_WIDTH-1:0])),
      .status      (trig)
   );

   // Handshake: the output register frees when empty or when its transfer completes.
   assign out_free       = !rsp_valid_ff || rsp_port.ready;
   assign s1_move        = s1_valid_ff && out_free;
   assign req_port.ready = trig.ready && (!s1_valid_ff || out_free);
   assign req_take       = req_port.valid && req_port.ready;
   assign s1_valid_in    = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in   = s1_move || (rsp_valid_ff && !rsp_port.ready);

   // Rotation: row vector times the rotation matrix, rounded half up.
   assign prod_xc = PROD_WIDTH'(pt_x_ff) * PROD_WIDTH'(trig.cosine);
   assign prod_ys = PROD_WIDTH'(pt_y_ff) * PROD_WIDTH'(trig.sine);
   assign prod_yc = PROD_WIDTH'(pt_y_ff) * PROD_WIDTH'(trig.cosine);
   assign prod_xs = PROD_WIDTH'(pt_x_ff) * PROD_WIDTH'(trig.sine);
   assign sum_x   = SUM_WIDTH'(prod_xc) + SUM_WIDTH'(prod_ys) + SUM_HALF;
   assign sum_y   = SUM_WIDTH'(prod_yc) - SUM_WIDTH'(prod_xs) + SUM_HALF;
   assign shr_x   = sum_x >>> prt2d_pkg::TRIG_FRAC_BITS;
   assign shr_y   = sum_y >>> prt2d_pkg::TRIG_FRAC_BITS;

   // Select the transform, then saturate each coordinate.
   always_comb begin
      if (mode_ff == prt2d_pkg::MODE_ROTATE) begin
         raw_x = shr_x[RAW_WIDTH-1:0];
         raw_y = shr_y[RAW_WIDTH-1:0];
      end else begin
         raw_x = RAW_WIDTH'(pt_x_ff) + RAW_WIDTH'(off_x_ff);
         raw_y = RAW_WIDTH'(pt_y_ff) + RAW_WIDTH'(off_y_ff);
      end
      sat_x = saturate(raw_x);
      sat_y = saturate(raw_y);
   end

   // Valid flags of the input and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         pt_x_ff <= req_port.point_x;
         pt_y_ff <= req_port.point_y;
      end
      if (s1_move) begin
         rsp_x_ff    <= sat_x.value;
         rsp_y_ff    <= sat_y.value;
         rsp_clip_ff <= sat_x.clip || sat_y.clip;
      end
   end

   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.result_x = rsp_x_ff;
   assign rsp_port.result_y = rsp_y_ff;
   assign rsp_port.clipped  = rsp_clip_ff;

endmodule
